/* src/tvbb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvbb_pkg
// Types and constants for the timed-volume bang-bang controller.
// ----------------------------------------------------------------------------
package tvbb_pkg;

    // Command codes
    localparam logic [1:0] CMD_STEP   = 2'd0;
    localparam logic [1:0] CMD_TARGET = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Motor direction codes (two's complement)
    localparam logic signed [1:0] DIR_STOP = 2'sd0;
    localparam logic signed [1:0] DIR_IN   = 2'sd1;
    localparam logic signed [1:0] DIR_OUT  = -2'sd1;

    // Configuration register map
    localparam int          PADDR_W        = 2;
    localparam logic [1:0]  ADDR_US_PER_CC = 2'd0;
    localparam logic [30:0] US_PER_CC_RST  = 31'd129948;

    // Datapath widths
    localparam int COMMIT_W = 48;
    localparam int TOTAL_W  = COMMIT_W + 1;
    localparam int DIVR_W   = 31;
    localparam int DIV_STEPS = COMMIT_W;
    localparam int CNT_W    = $clog2(DIV_STEPS);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ABS,
        ST_DIV,
        ST_FIN
    } state_t;

    // Input item
    typedef struct packed {
        logic        [1:0]  cmd;
        logic        [31:0] now_us;
        logic signed [15:0] target_cc;
    } item_t;

    // Result item
    typedef struct packed {
        logic signed [1:0]  motor_dir;
        logic signed [15:0] volume_cc;
        logic               changed;
    } result_t;

endpackage

/* src/timed_volume_bang_bang_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_volume_bang_bang_controller
// Dead-reckons pumped volume from motor run time and drives a three-state
// motor toward a target volume. One shared restoring divider (one quotient
// bit per cycle) turns signed run time into cc.
// ----------------------------------------------------------------------------
// Sequence: a clear command goes straight to the finish state; every other
//   command passes through sum, magnitude, 48 divider steps and finish.
// The block takes one item at a time, set by the 48-step serial divider; a
//   new item is taken once the previous result is written, which a result stall can hold off.
// Reset (rst_n low, async): state cleared, motor stopped, us_per_cc = 129948.

module timed_volume_bang_bang_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    // item channel
    input  logic                          item_valid,
    output logic                          item_stall,
    input  tvbb_pkg::item_t               item,
    // result channel
    output logic                          result_valid,
    input  logic                          result_stall,
    output tvbb_pkg::result_t             result,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tvbb_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int CW = tvbb_pkg::COMMIT_W;
    localparam int TW = tvbb_pkg::TOTAL_W;
    localparam int DW = tvbb_pkg::DIVR_W;
    localparam int NW = tvbb_pkg::CNT_W;

    // Sequencer
    tvbb_pkg::state_t state_reg, state_next;

    // Architectural state
    logic        [CW-1:0] committed_reg, committed_next;
    logic signed [1:0]    dir_reg,       dir_next;
    logic        [31:0]   seg_start_reg, seg_start_next;
    logic signed [15:0]   target_reg,    target_next;
    logic        [DW-1:0] us_per_cc_reg, us_per_cc_next;

    // Working registers
    tvbb_pkg::item_t      item_reg,  item_next;
    logic        [TW-1:0] total_reg, total_next;
    logic        [CW-1:0] quo_reg,   quo_next;
    logic        [DW-1:0] rem_reg,   rem_next;
    logic        [NW-1:0] count_reg, count_next;

    // Result register
    logic                 out_valid_reg, out_valid_next;
    tvbb_pkg::result_t    out_reg,       out_next;

    // Control
    logic                 accept;
    logic                 fin_go;
    logic                 cfg_wr;

    // Datapath nets
    logic        [DW-1:0] div_val;
    logic        [31:0]   elapsed;
    logic        [TW-1:0] live_term;
    logic                 live_cin;
    logic        [DW:0]   rem_shift;
    logic        [DW+1:0] rem_diff;
    logic                 q_bit;
    logic signed [15:0]   vol;
    logic        [16:0]   err;
    logic signed [1:0]    desired;
    logic                 is_neg;

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr == tvbb_pkg::ADDR_US_PER_CC);

    always_comb
    begin
        if (paddr == tvbb_pkg::ADDR_US_PER_CC)
            prdata = {1'b0, us_per_cc_reg};
        else
            prdata = '0;
    end

    always_comb
    begin
        us_per_cc_next = cfg_wr ? pwdata[DW-1:0] : us_per_cc_reg;
    end

    // A divisor of zero acts as one
    assign div_val = (us_per_cc_reg == '0) ? DW'(1) : us_per_cc_reg;

    // ------------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tvbb_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = (item.cmd == tvbb_pkg::CMD_CLEAR) ?
                                 tvbb_pkg::ST_FIN : tvbb_pkg::ST_LOAD;
            end
            tvbb_pkg::ST_LOAD: state_next = tvbb_pkg::ST_ABS;
            tvbb_pkg::ST_ABS:  state_next = tvbb_pkg::ST_DIV;
            tvbb_pkg::ST_DIV:
            begin
                if (count_reg == NW'(tvbb_pkg::DIV_STEPS - 1))
                    state_next = tvbb_pkg::ST_FIN;
            end
            tvbb_pkg::ST_FIN:
            begin
                if (fin_go)
                    state_next = tvbb_pkg::ST_IDLE;
            end
            default: state_next = tvbb_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------------
    always_comb
    begin
        item_stall = (state_reg != tvbb_pkg::ST_IDLE);
        fin_go     = (state_reg == tvbb_pkg::ST_FIN) && (!out_valid_reg || !result_stall);
    end

    assign accept = item_valid && !item_stall;

    // ------------------------------------------------------------------------
    // Running total: committed + elapsed * direction (one adder, carry-in negate)
    // ------------------------------------------------------------------------
    always_comb
    begin
        elapsed  = item_reg.now_us - seg_start_reg;
        live_cin = (dir_reg == tvbb_pkg::DIR_OUT);
        if (dir_reg == tvbb_pkg::DIR_STOP)
            live_term = '0;
        else if (live_cin)
            live_term = ~{{(TW-32){elapsed[31]}}, elapsed};
        else
            live_term = {{(TW-32){elapsed[31]}}, elapsed};
    end

    // ------------------------------------------------------------------------
    // Restoring divider step
    // ------------------------------------------------------------------------
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[CW-1]};
        rem_diff  = {1'b0, rem_shift} - {2'b00, div_val};
        q_bit     = !rem_diff[DW+1];
    end

    // ------------------------------------------------------------------------
    // Finish: saturate quotient, pick direction
    // ------------------------------------------------------------------------
    always_comb
    begin
        is_neg = total_reg[TW-1];
        if (item_reg.cmd == tvbb_pkg::CMD_CLEAR)
            vol = '0;
        else if (is_neg)
            vol = (quo_reg > CW'(32768)) ? -16'sd32768 : -$signed(quo_reg[15:0]);
        else
            vol = (quo_reg > CW'(32767)) ? 16'sd32767 : $signed(quo_reg[15:0]);

        err = {target_reg[15], target_reg} - {vol[15], vol};
        if (err == '0)
            desired = tvbb_pkg::DIR_STOP;
        else if (err[16])
            desired = tvbb_pkg::DIR_OUT;
        else
            desired = tvbb_pkg::DIR_IN;
    end

    // ------------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------------
    always_comb
    begin
        item_next      = item_reg;
        total_next     = total_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        count_next     = count_reg;
        committed_next = committed_reg;
        dir_next       = dir_reg;
        seg_start_next = seg_start_reg;
        target_next    = target_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;

        if (accept)
            item_next = item;

        case (state_reg)
            tvbb_pkg::ST_LOAD:
            begin
                total_next = {committed_reg[CW-1], committed_reg} + live_term
                             + TW'(live_cin);
            end
            tvbb_pkg::ST_ABS:
            begin
                quo_next   = is_neg ? CW'(-total_reg) : total_reg[CW-1:0];
                rem_next   = '0;
                count_next = '0;
            end
            tvbb_pkg::ST_DIV:
            begin
                rem_next   = q_bit ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
                quo_next   = {quo_reg[CW-2:0], q_bit};
                count_next = count_reg + NW'(1);
            end
            tvbb_pkg::ST_FIN:
            begin
                if (fin_go)
                begin
                    out_valid_next    = 1'b1;
                    out_next.changed  = 1'b0;
                    out_next.volume_cc = vol;
                    case (item_reg.cmd)
                        tvbb_pkg::CMD_CLEAR:
                        begin
                            out_next.changed = (dir_reg != tvbb_pkg::DIR_STOP);
                            committed_next   = '0;
                            dir_next         = tvbb_pkg::DIR_STOP;
                            seg_start_next   = '0;
                            target_next      = '0;
                        end
                        tvbb_pkg::CMD_TARGET:
                        begin
                            target_next = item_reg.target_cc;
                        end
                        tvbb_pkg::CMD_STEP:
                        begin
                            if (desired != dir_reg)
                            begin
                                if (dir_reg != tvbb_pkg::DIR_STOP)
                                    committed_next = total_reg[CW-1:0];
                                if (desired != tvbb_pkg::DIR_STOP)
                                    seg_start_next = item_reg.now_us;
                                dir_next         = desired;
                                out_next.changed = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    out_next.motor_dir = dir_next;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tvbb_pkg::ST_IDLE;
            committed_reg <= '0;
            dir_reg       <= tvbb_pkg::DIR_STOP;
            seg_start_reg <= '0;
            target_reg    <= '0;
            us_per_cc_reg <= tvbb_pkg::US_PER_CC_RST;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            committed_reg <= committed_next;
            dir_reg       <= dir_next;
            seg_start_reg <= seg_start_next;
            target_reg    <= target_next;
            us_per_cc_reg <= us_per_cc_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        total_reg <= total_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        out_reg   <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == tvbb_pkg::ST_FIN)
        else $error("result appeared without a finish step");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tvbb_pkg::ST_DIV |-> count_reg < NW'(tvbb_pkg::DIV_STEPS))
        else $error("divider step count out of range");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tvbb_pkg::ST_DIV |-> rem_reg < div_val)
        else $error("partial remainder not below divisor");

    a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
        dir_reg != 2'b10)
        else $error("invalid motor direction code");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fin_go && item_reg.cmd == tvbb_pkg::CMD_CLEAR
        |=> dir_reg == tvbb_pkg::DIR_STOP && committed_reg == '0)
        else $error("clear command left state behind");

endmodule

/* bench/timed_volume_bang_bang_controller_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_volume_bang_bang_controller_tb
// Self-checking bench for the bang-bang volume controller. A queue-fed driver
// sends command transfers with random gaps, and a monitor with random stalls
// compares every result against a cycle-free model of the dead-reckoned
// volume and motor direction. The us_per_cc register is swept between phases.
// ----------------------------------------------------------------------------

module timed_volume_bang_bang_controller_tb;

    // the fourth command code has no meaning; the block just reports status
    localparam logic [1:0] CMD_NONE = 2'd3;

    typedef enum int {PACE_NONE, PACE_LIGHT, PACE_HEAVY} pace_t;

    typedef struct {
        tvbb_pkg::item_t it;
        int unsigned     gap;
        bit              wait_empty;
    } pending_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          item_valid = 1'b0;
    logic                          item_stall;
    tvbb_pkg::item_t               item = '0;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    tvbb_pkg::result_t             result;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [tvbb_pkg::PADDR_W-1:0]  paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    // controller model state
    logic signed [47:0]    commit_us = '0;
    logic signed [1:0]     pump_dir = tvbb_pkg::DIR_STOP;
    logic [31:0]           seg_start_us = '0;
    logic signed [15:0]    target_vol = '0;
    logic [30:0]           cc_period = tvbb_pkg::US_PER_CC_RST;

    pending_t              pending_q[$];
    tvbb_pkg::result_t     expected_q[$];
    int unsigned           idle_cycles = 0;
    int unsigned           stall_left = 0;
    int unsigned           sink_hold;
    pace_t                 src_pace = PACE_NONE;
    pace_t                 sink_pace = PACE_NONE;
    logic [31:0]           stamp_us = '0;
    int                    fail_cnt = 0;

    timed_volume_bang_bang_controller DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // wait cycles for one transfer
    function automatic int unsigned draw_wait(pace_t p);
        case (p)
            PACE_NONE:  return 0;
            PACE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 0;
            default:    return $urandom_range(0, 18);
        endcase
    endfunction

    // signed run time of the live segment; backward time reads as negative
    function automatic longint live_us(logic [31:0] now);
        logic [31:0] d;
        d = now - seg_start_us;
        return longint'($signed(d)) * longint'(pump_dir);
    endfunction

    // volume in cc, truncated toward zero and clamped to 16 bits
    function automatic logic signed [15:0] estimate_cc(logic [31:0] now);
        longint total;
        longint divisor;
        longint q;
        total = commit_us;
        total = total + live_us(now);
        divisor = (cc_period == 0) ? 64'sd1 : longint'(cc_period);
        q = total / divisor;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return 16'(q);
    endfunction

    // apply one command to the model and return its result
    function automatic tvbb_pkg::result_t pump_step(tvbb_pkg::item_t it);
        tvbb_pkg::result_t r;
        int                vol;
        int                err;
        logic signed [1:0] want;
        r = '0;
        if (it.cmd == tvbb_pkg::CMD_CLEAR)
        begin
            r.changed = (pump_dir != tvbb_pkg::DIR_STOP);
            commit_us = '0;
            pump_dir = tvbb_pkg::DIR_STOP;
            seg_start_us = '0;
            target_vol = '0;
        end
        else
        begin
            if (it.cmd == tvbb_pkg::CMD_TARGET)
                target_vol = it.target_cc;
            vol = estimate_cc(it.now_us);
            if (it.cmd == tvbb_pkg::CMD_STEP)
            begin
                err = int'(target_vol) - vol;
                want = (err > 0) ? tvbb_pkg::DIR_IN :
                       ((err < 0) ? tvbb_pkg::DIR_OUT : tvbb_pkg::DIR_STOP);
                if (want != pump_dir)
                begin
                    if (pump_dir != tvbb_pkg::DIR_STOP)
                        commit_us = commit_us + 48'(live_us(it.now_us));
                    pump_dir = want;
                    if (want != tvbb_pkg::DIR_STOP)
                        seg_start_us = it.now_us;
                    r.changed = 1'b1;
                end
            end
            r.volume_cc = 16'(vol);
        end
        r.motor_dir = pump_dir;
        return r;
    endfunction

    task automatic queue_item(logic [1:0] cmd, logic [31:0] now, logic [15:0] tgt);
        pending_t p;
        p.it.cmd = cmd;
        p.it.now_us = now;
        p.it.target_cc = tgt;
        p.gap = draw_wait(src_pace);
        p.wait_empty = 1'b0;
        pending_q.push_back(p);
    endtask

    // register write: setup cycle, then access cycle
    task automatic write_us_per_cc(logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= tvbb_pkg::ADDR_US_PER_CC;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cc_period = value[30:0];
    endtask

    // block until every queued transfer is sent and every result is back
    task automatic settle_all();
        while (pending_q.size() != 0 || item_valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // mostly control steps with forward time; some targets, clears, no-op commands, time jumps
    task automatic queue_random_traffic(int count, logic [31:0] span, int tgt_lim);
        int          pick;
        logic [15:0] tgt;
        for (int n = 0; n < count; n++)
        begin
            if (n % 60 == 0)
                src_pace = pace_t'($urandom_range(0, 2));
            pick = $urandom_range(0, 99);
            tgt = 16'($urandom);
            if (pick < 70)
            begin
                stamp_us = stamp_us + $urandom_range(0, span);
                queue_item(tvbb_pkg::CMD_STEP, stamp_us, tgt);
            end
            else if (pick < 84)
            begin
                if ($urandom_range(0, 19) != 0)
                    tgt = 16'(int'($urandom_range(0, 2 * tgt_lim)) - tgt_lim);
                queue_item(tvbb_pkg::CMD_TARGET, stamp_us, tgt);
            end
            else if (pick < 88)
                queue_item(tvbb_pkg::CMD_CLEAR, stamp_us, tgt);
            else if (pick < 90)
                queue_item(CMD_NONE, stamp_us, tgt);
            else if (pick < 95)
            begin
                stamp_us = stamp_us - $urandom_range(0, span);
                queue_item(tvbb_pkg::CMD_STEP, stamp_us, tgt);
            end
            else
            begin
                stamp_us = $urandom;
                queue_item(tvbb_pkg::CMD_STEP, stamp_us, tgt);
            end
            // hold the sender until the block has drained
            if (n == count / 2 || $urandom_range(0, 199) == 0)
                pending_q[pending_q.size() - 1].wait_empty = 1'b1;
        end
    endtask

    task automatic run_phase(logic [31:0] period, logic [31:0] span, int tgt_lim,
                             int count);
        write_us_per_cc(period);
        queue_random_traffic(count, span, tgt_lim);
        settle_all();
    endtask

    // driver: one transfer per pending entry after its gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                expected_q.push_back(pump_step(item));
            if (!item_valid || !item_stall)
            begin
                if (pending_q.size() != 0 && idle_cycles >= pending_q[0].gap &&
                    (!pending_q[0].wait_empty || expected_q.size() == 0))
                begin
                    item <= pending_q[0].it;
                    item_valid <= 1'b1;
                    idle_cycles <= 0;
                    pending_q.pop_front();
                end
                else
                begin
                    item_valid <= 1'b0;
                    idle_cycles <= idle_cycles + 1;
                end
            end
        end
    end

    // monitor: check each result transfer, then stall for a random while
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (result_valid && !result_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result transfer: motor_dir %0d volume_cc %0d changed %0d",
                       result.motor_dir, result.volume_cc, result.changed);
                fail_cnt++;
            end
            else
            begin
                tvbb_pkg::result_t want;
                want = expected_q.pop_front();
                if (result.motor_dir !== want.motor_dir)
                begin
                    $error("motor_dir: expected %0d, actual %0d",
                           want.motor_dir, result.motor_dir);
                    fail_cnt++;
                end
                if (result.volume_cc !== want.volume_cc)
                begin
                    $error("volume_cc: expected %0d, actual %0d",
                           want.volume_cc, result.volume_cc);
                    fail_cnt++;
                end
                if (result.changed !== want.changed)
                begin
                    $error("changed: expected %0d, actual %0d",
                           want.changed, result.changed);
                    fail_cnt++;
                end
            end
            sink_hold = draw_wait(sink_pace);
            stall_left <= sink_hold;
            result_stall <= (sink_hold != 0);
            if ($urandom_range(0, 39) == 0)
                sink_pace = pace_t'($urandom_range(0, 2));
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            result_stall <= (stall_left > 1);
        end
    end

    // stimulus sequence
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: default divisor, full-scale targets, time jumps and wrap
        write_us_per_cc(32'(tvbb_pkg::US_PER_CC_RST));
        queue_item(tvbb_pkg::CMD_STEP, 32'd0, 16'h5555);
        queue_item(tvbb_pkg::CMD_TARGET, 32'd10, 16'h7FFF);
        queue_item(tvbb_pkg::CMD_STEP, 32'd1000, 16'hAAAA);
        queue_item(tvbb_pkg::CMD_STEP, 32'd650740, 16'h0000);
        queue_item(CMD_NONE, 32'd700000, 16'hFFFF);
        queue_item(tvbb_pkg::CMD_TARGET, 32'd800000, 16'h8000);
        queue_item(tvbb_pkg::CMD_STEP, 32'd900000, 16'h1234);
        queue_item(tvbb_pkg::CMD_STEP, 32'd400000, 16'h0000);
        queue_item(tvbb_pkg::CMD_STEP, 32'hFFFF_FF00, 16'h0000);
        queue_item(tvbb_pkg::CMD_CLEAR, 32'd5, 16'h0000);
        queue_item(tvbb_pkg::CMD_CLEAR, 32'd6, 16'h0000);
        queue_item(tvbb_pkg::CMD_TARGET, 32'hFFFF_FFFF, 16'hFFFD);
        queue_item(tvbb_pkg::CMD_STEP, 32'hFFFF_FFFF, 16'h0000);
        queue_item(tvbb_pkg::CMD_STEP, 32'd520000, 16'h0000);
        settle_all();

        // directed: one us per cc drives the estimate into both clamps
        write_us_per_cc(32'd1);
        queue_item(tvbb_pkg::CMD_TARGET, 32'd0, 16'h7FFF);
        queue_item(tvbb_pkg::CMD_STEP, 32'd0, 16'h0000);
        queue_item(tvbb_pkg::CMD_STEP, 32'd40000, 16'h0000);
        queue_item(tvbb_pkg::CMD_STEP, 32'd100000, 16'h0000);
        queue_item(tvbb_pkg::CMD_TARGET, 32'd100000, 16'h8000);
        queue_item(tvbb_pkg::CMD_STEP, 32'h8000_0000, 16'h0000);
        queue_item(tvbb_pkg::CMD_STEP, 32'd0, 16'h0000);
        queue_item(tvbb_pkg::CMD_STEP, 32'h8001_86A0, 16'h0000);
        settle_all();

        // directed: a zero divisor behaves as one
        write_us_per_cc(32'd0);
        queue_item(tvbb_pkg::CMD_TARGET, 32'd0, 16'd5);
        queue_item(tvbb_pkg::CMD_STEP, 32'd0, 16'h0000);
        queue_item(tvbb_pkg::CMD_STEP, 32'd3, 16'h0000);
        queue_item(tvbb_pkg::CMD_STEP, 32'd10, 16'h0000);
        queue_item(tvbb_pkg::CMD_CLEAR, 32'd11, 16'h0000);
        settle_all();

        // random phases over the divisor range
        run_phase(32'd1, 32'd8, 40, 250);
        run_phase(32'(tvbb_pkg::US_PER_CC_RST), 32'd500000, 30, 250);
        run_phase(32'd7, 32'd60, 30, 250);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 2, 250);
        run_phase(32'd1000, 32'd6000, 25, 250);
        run_phase(32'd0, 32'd8, 40, 250);

        repeat (60) @(posedge clk);
        if (fail_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
src/tvbb_pkg.sv
src/timed_volume_bang_bang_controller.sv
bench/timed_volume_bang_bang_controller_tb.sv
